// ----- hw/rtl/sdia_pkg.sv -----
// ---------------------------------------------------------------------------
// sdia_pkg
// Shared types, codes and saturation helpers for the sample ring averager.
// ---------------------------------------------------------------------------
package sdia_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int SLOT_W      = 10;
  localparam int AVERAGE_MAX = 16;

  // shared iterative unit widths
  localparam int UNIT_A_W   = 52;
  localparam int UNIT_B_W   = 32;
  localparam int UNIT_P_W   = UNIT_A_W + UNIT_B_W;
  localparam int MUL_STEPS  = UNIT_B_W;
  localparam int DIV_STEPS  = UNIT_A_W;
  localparam int STEP_W     = 6;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_SCALE  = 3'd1;
  localparam logic [2:0] CFG_OFFSET = 3'd2;
  localparam logic [2:0] CFG_PERIOD = 3'd3;
  localparam logic [2:0] CFG_SPAN   = 3'd4;

  // transform modes
  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_DERIV = 2'd1;
  localparam logic [1:0] MODE_INTEG = 2'd2;
  localparam logic [1:0] MODE_CUMUL = 2'd3;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic signed [51:0] MAX48_W = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] MIN48_W = -52'sh0_8000_0000_0000;
  localparam logic signed [47:0] MAX48   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48   = 48'sh8000_0000_0000;

  typedef struct packed {
    logic                go;
    logic                op_div;
    logic [UNIT_A_W-1:0] a;
    logic [UNIT_B_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic                done;
    logic [UNIT_P_W-1:0] prod;
    logic [UNIT_A_W-1:0] quo;
    logic [UNIT_B_W-1:0] rem;
  } unit_rsp_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] x);
    if (x > MAX48_W) return MAX48;
    if (x < MIN48_W) return MIN48;
    return x[47:0];
  endfunction

  // sign applied to a magnitude, clipped to 48 signed bits
  function automatic logic signed [47:0] signed_sat(input logic neg, input logic [63:0] m);
    logic [63:0] nm;
    nm = 64'd0 - m;
    if (neg) begin
      if (m > 64'h0000_8000_0000_0000) return MIN48;
      return signed'(nm[47:0]);
    end
    if (m > 64'h0000_7FFF_FFFF_FFFF) return MAX48;
    return signed'(m[47:0]);
  endfunction

endpackage

// ----- hw/rtl/sdia_iter_unit.sv -----
// ---------------------------------------------------------------------------
// sdia_iter_unit
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ---------------------------------------------------------------------------
module sdia_iter_unit (
  input  logic                clk,
  input  logic                rst,
  input  sdia_pkg::unit_req_t req,
  output sdia_pkg::unit_rsp_t rsp
);

  logic                              active;
  logic                              op_div;
  logic                              done;
  logic [sdia_pkg::STEP_W-1:0]       step;
  logic [sdia_pkg::UNIT_P_W:0]       pr;
  logic [sdia_pkg::UNIT_B_W-1:0]     rem;
  logic [sdia_pkg::UNIT_B_W-1:0]     dvsr;
  logic [sdia_pkg::UNIT_A_W-1:0]     mcand;
  logic [sdia_pkg::UNIT_A_W:0]       mul_sum;
  logic [sdia_pkg::UNIT_B_W:0]       trial;
  logic                              ge;
  logic                              last;

  always_comb begin
    mul_sum = pr[sdia_pkg::UNIT_P_W:sdia_pkg::UNIT_B_W]
            + (pr[0] ? {1'b0, mcand} : '0);
    trial   = {rem, pr[sdia_pkg::UNIT_A_W-1]};
    ge      = trial >= {1'b0, dvsr};
    last    = op_div ? (step == sdia_pkg::STEP_W'(sdia_pkg::DIV_STEPS - 1))
                     : (step == sdia_pkg::STEP_W'(sdia_pkg::MUL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
      end else if (active && last) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_div <= req.op_div;
      mcand  <= req.a;
      dvsr   <= req.b;
      step   <= '0;
      rem    <= '0;
      if (req.op_div) begin
        pr <= (sdia_pkg::UNIT_P_W + 1)'(req.a);
      end else begin
        pr <= (sdia_pkg::UNIT_P_W + 1)'(req.b);
      end
    end else if (active) begin
      step <= step + 1'b1;
      if (op_div) begin
        rem <= ge ? sdia_pkg::UNIT_B_W'(trial - {1'b0, dvsr})
                  : trial[sdia_pkg::UNIT_B_W-1:0];
        pr[sdia_pkg::UNIT_A_W-1:0] <= {pr[sdia_pkg::UNIT_A_W-2:0], ge};
      end else begin
        pr <= {1'b0, mul_sum, pr[sdia_pkg::UNIT_B_W-1:1]};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = pr[sdia_pkg::UNIT_P_W-1:0];
  assign rsp.quo  = pr[sdia_pkg::UNIT_A_W-1:0];
  assign rsp.rem  = rem;

endmodule

// ----- hw/rtl/sample_derivative_integral_averager.sv -----
// ---------------------------------------------------------------------------
// sample_derivative_integral_averager
// Sample ring with raw / derivative / integral / cumulative transform and a
// scaled moving-average read.
// ---------------------------------------------------------------------------
// One word at a time: a word is taken when start is high and busy is low, and
// busy stays high until its single result has gone out. The result appears on
// out_value/out_valid for exactly one cycle with done high; the receiver
// cannot stall it, so capture it then. An insert in raw mode or on the simple
// cases needs no pass of the shared unit; a cyclic derivative makes two passes
// of the divider, and a cyclic integral needs the divider and then the
// multiplier. A read makes one multiplier pass per valid entry walked, for the
// scaling, and one divider pass for the final divide. All of these passes share
// the one multiply/divide unit. After reset the block clears every entry of
// both ring memories, busy high throughout; configuration writes are taken at
// any time (cfg_ready is tied high) but should only be made while idle.
// ---------------------------------------------------------------------------
module sample_derivative_integral_averager (
  input  logic                clk,
  input  logic                rst,
  // item port
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic [9:0]          slot_index,
  input  logic [9:0]          window_start,
  input  logic signed [31:0]  sample_value,
  input  logic                sample_present,
  input  logic                first_sample,
  input  logic [31:0]         time_step,
  // result port
  output logic                done,
  output logic signed [47:0]  out_value,
  output logic                out_valid,
  // configuration port
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int SW = sdia_pkg::SLOT_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_INS_LOAD = 4'd2;
  localparam logic [3:0] ST_WRAP     = 4'd3;
  localparam logic [3:0] ST_FORM     = 4'd4;
  localparam logic [3:0] ST_DER_DIV  = 4'd5;
  localparam logic [3:0] ST_INT_MUL  = 4'd6;
  localparam logic [3:0] ST_INT_ACC  = 4'd7;
  localparam logic [3:0] ST_RD_DATA  = 4'd8;
  localparam logic [3:0] ST_RD_MUL   = 4'd9;
  localparam logic [3:0] ST_RD_ACC   = 4'd10;
  localparam logic [3:0] ST_RD_NEXT  = 4'd11;
  localparam logic [3:0] ST_RD_AVG   = 4'd12;
  localparam logic [3:0] ST_FINISH   = 4'd13;

  logic [3:0]          state;
  logic [SW-1:0]       clr_addr;

  // configuration
  logic [1:0]          mode;
  logic signed [31:0]  scale;
  logic signed [31:0]  offset;
  logic [4:0]          avg_period;
  logic [30:0]         span;

  // latched word
  logic                kind_r;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       wstart_r;
  logic signed [31:0]  cur;
  logic                present_r;
  logic                first_r;
  logic [31:0]         dt;

  // working registers
  logic signed [32:0]  diff;
  logic signed [47:0]  t_val;
  logic                t_ok;
  logic [SW-1:0]       pos;
  logic [4:0]          idx;
  logic [4:0]          vcnt;
  logic signed [51:0]  sum;

  // ring memories: {valid, value}
  logic [32:0]         smem [sdia_pkg::RING_DEPTH];
  logic [48:0]         tmem [sdia_pkg::RING_DEPTH];
  logic                s_we, s_re, t_we, t_re;
  logic [SW-1:0]       s_wa, s_ra, t_wa, t_ra;
  logic [32:0]         s_wd, s_rd;
  logic [48:0]         t_wd, t_rd;

  sdia_pkg::unit_req_t req;
  sdia_pkg::unit_rsp_t rsp;

  logic                accept;
  logic signed [31:0]  p;
  logic                pv;
  logic signed [47:0]  pt;
  logic                ptv;
  logic signed [32:0]  diff_raw;
  logic [32:0]         diff_mag;
  logic [32:0]         draw_mag;
  logic signed [34:0]  n_s;
  logic [34:0]         n_mag;
  logic [47:0]         pt_mag;
  logic [31:0]         scale_mag;
  logic [51:0]         sum_mag;
  logic [4:0]          period;
  logic                need_wrap;
  logic                rd_empty_first;
  logic                rd_last;
  logic [30:0]         wrap_r;
  logic [30:0]         wrap_w;
  logic                wrap_hi;

  sdia_iter_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd <= smem[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    if (t_re) begin
      t_rd <= tmem[t_ra];
    end
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    p        = signed'(s_rd[31:0]);
    pv       = s_rd[32];
    pt       = signed'(t_rd[47:0]);
    ptv      = t_rd[48];
    diff_raw = 33'(cur) - 33'(p);
    draw_mag = diff_raw[32] ? 33'(-diff_raw) : 33'(diff_raw);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    n_s      = (35'(p) <<< 1) + 35'(diff);
    n_mag    = n_s[34] ? 35'(-n_s) : 35'(n_s);
    pt_mag   = pt[47] ? 48'(-pt) : 48'(pt);
    scale_mag = scale[31] ? 32'(-scale) : 32'(scale);
    sum_mag  = sum[51] ? 52'(-sum) : 52'(sum);
    // period clamps to 1..AVERAGE_MAX
    if (avg_period == 5'd0) begin
      period = 5'd1;
    end else if (avg_period > 5'(sdia_pkg::AVERAGE_MAX)) begin
      period = 5'(sdia_pkg::AVERAGE_MAX);
    end else begin
      period = avg_period;
    end
    need_wrap = (span != 31'd0) && (mode == sdia_pkg::MODE_DERIV || ptv);
    rd_empty_first = (idx == 5'd0) && (vcnt == 5'd0);
    rd_last        = (idx == period - 5'd1);
    // wrap remainder into [-span/2, span/2)
    wrap_r  = rsp.rem[30:0];
    wrap_w  = (diff[32] && wrap_r != 31'd0) ? span - wrap_r : wrap_r;
    wrap_hi = {wrap_w, 1'b0} >= {1'b0, span};
  end

  // memory ports
  always_comb begin
    s_we = (state == ST_CLEAR) || (accept && kind == sdia_pkg::KIND_INSERT);
    s_wa = (state == ST_CLEAR) ? clr_addr : slot_index;
    s_wd = (state == ST_CLEAR || !sample_present) ? 33'd0 : {1'b1, sample_value};
    s_re = accept && kind == sdia_pkg::KIND_INSERT;
    s_ra = slot_index - 1'b1;
    t_we = (state == ST_CLEAR) || (state == ST_FINISH && kind_r == sdia_pkg::KIND_INSERT);
    t_wa = (state == ST_CLEAR) ? clr_addr : slot_r;
    t_wd = (state == ST_CLEAR) ? 49'd0 : {t_ok, t_val};
    t_re = accept || (state == ST_RD_NEXT && !rd_empty_first && !rd_last && pos != wstart_r);
    if (accept) begin
      t_ra = (kind == sdia_pkg::KIND_READ) ? slot_index : slot_index - 1'b1;
    end else begin
      t_ra = pos - 1'b1;
    end
  end

  // shared unit requests
  always_comb begin
    req = '0;
    unique case (state)
      ST_INS_LOAD: begin
        if (present_r && !first_r && pv && need_wrap &&
            ((mode == sdia_pkg::MODE_DERIV && dt != 32'd0) ||
             mode == sdia_pkg::MODE_INTEG || mode == sdia_pkg::MODE_CUMUL)) begin
          req.go     = 1'b1;
          req.op_div = 1'b1;
          req.a      = 52'(draw_mag);
          req.b      = 32'(span);
        end
      end
      ST_FORM: begin
        if (mode == sdia_pkg::MODE_DERIV) begin
          req.go     = 1'b1;
          req.op_div = 1'b1;
          req.a      = 52'({diff_mag, 16'd0});
          req.b      = dt;
        end else if (mode == sdia_pkg::MODE_INTEG) begin
          req.go = 1'b1;
          req.a  = 52'(n_mag);
          req.b  = dt;
        end
      end
      ST_RD_DATA: begin
        if (ptv) begin
          req.go = 1'b1;
          req.a  = 52'(pt_mag);
          req.b  = scale_mag;
        end
      end
      ST_RD_NEXT: begin
        if (!rd_empty_first && rd_last) begin
          req.go     = 1'b1;
          req.op_div = 1'b1;
          req.a      = sum_mag;
          req.b      = 32'(vcnt);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      mode       <= sdia_pkg::MODE_RAW;
      scale      <= 32'sd65536;
      offset     <= '0;
      avg_period <= 5'd1;
      span       <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sdia_pkg::CFG_MODE:   mode       <= cfg_data[1:0];
          sdia_pkg::CFG_SCALE:  scale      <= signed'(cfg_data);
          sdia_pkg::CFG_OFFSET: offset     <= signed'(cfg_data);
          sdia_pkg::CFG_PERIOD: avg_period <= cfg_data[4:0];
          sdia_pkg::CFG_SPAN:   span       <= cfg_data[30:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            kind_r    <= kind;
            slot_r    <= slot_index;
            wstart_r  <= window_start;
            cur       <= sample_value;
            present_r <= sample_present;
            first_r   <= first_sample;
            dt        <= time_step;
            pos       <= slot_index;
            idx       <= '0;
            vcnt      <= '0;
            sum       <= '0;
            state     <= (kind == sdia_pkg::KIND_READ) ? ST_RD_DATA : ST_INS_LOAD;
          end
        end

        // previous slot's sample and transform are on the read ports now
        ST_INS_LOAD: begin
          diff  <= diff_raw;
          t_val <= '0;
          t_ok  <= 1'b0;
          state <= ST_FINISH;
          if (!present_r) begin
            t_ok <= 1'b0;
          end else if (first_r) begin
            t_ok <= (mode != sdia_pkg::MODE_DERIV);
            if (mode == sdia_pkg::MODE_RAW || mode == sdia_pkg::MODE_CUMUL) begin
              t_val <= 48'(cur);
            end
          end else begin
            unique case (mode)
              sdia_pkg::MODE_RAW: begin
                t_val <= 48'(cur);
                t_ok  <= 1'b1;
              end
              sdia_pkg::MODE_DERIV: begin
                if (dt != 32'd0 && pv) begin
                  state <= need_wrap ? ST_WRAP : ST_FORM;
                end
              end
              sdia_pkg::MODE_INTEG: begin
                t_ok <= 1'b1;
                if (pv) begin
                  state <= need_wrap ? ST_WRAP : ST_FORM;
                end
              end
              sdia_pkg::MODE_CUMUL: begin
                t_ok <= 1'b1;
                if (!pv) begin
                  t_val <= 48'(cur);
                end else if (!ptv) begin
                  t_val <= 48'(p) + 48'(cur);
                end else begin
                  state <= need_wrap ? ST_WRAP : ST_FORM;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_WRAP: begin
          if (rsp.done) begin
            diff  <= wrap_hi ? 33'(wrap_w) - 33'(span) : 33'(wrap_w);
            state <= ST_FORM;
          end
        end

        ST_FORM: begin
          unique case (mode)
            sdia_pkg::MODE_DERIV: state <= ST_DER_DIV;
            sdia_pkg::MODE_INTEG: state <= ST_INT_MUL;
            default: begin
              t_val <= sdia_pkg::sat48(52'(pt) + 52'(p) + 52'(diff));
              t_ok  <= 1'b1;
              state <= ST_FINISH;
            end
          endcase
        end

        ST_DER_DIV: begin
          if (rsp.done) begin
            t_val <= sdia_pkg::signed_sat(diff[32], 64'(rsp.quo));
            t_ok  <= 1'b1;
            state <= ST_FINISH;
          end
        end

        // half of n * dt: product >> 17
        ST_INT_MUL: begin
          if (rsp.done) begin
            t_val <= sdia_pkg::signed_sat(n_s[34], 64'(rsp.prod[83:17]));
            state <= ST_INT_ACC;
          end
        end

        ST_INT_ACC: begin
          if (ptv) begin
            t_val <= sdia_pkg::sat48(52'(pt) + 52'(t_val));
          end
          state <= ST_FINISH;
        end

        ST_RD_DATA: begin
          state <= ptv ? ST_RD_MUL : ST_RD_NEXT;
        end

        ST_RD_MUL: begin
          if (rsp.done) begin
            t_val <= sdia_pkg::signed_sat(pt[47] ^ scale[31], 64'(rsp.prod[83:16]));
            state <= ST_RD_ACC;
          end
        end

        ST_RD_ACC: begin
          sum   <= sum + 52'(sdia_pkg::sat48(52'(t_val) + 52'(offset)));
          vcnt  <= vcnt + 1'b1;
          state <= ST_RD_NEXT;
        end

        ST_RD_NEXT: begin
          if (rd_empty_first) begin
            t_val <= '0;
            t_ok  <= 1'b0;
            state <= ST_FINISH;
          end else if (rd_last) begin
            state <= ST_RD_AVG;
          end else if (pos == wstart_r) begin
            // window start reached before the period filled
            t_val <= '0;
            t_ok  <= 1'b0;
            state <= ST_FINISH;
          end else begin
            pos   <= pos - 1'b1;
            idx   <= idx + 1'b1;
            state <= ST_RD_DATA;
          end
        end

        ST_RD_AVG: begin
          if (rsp.done) begin
            t_val <= sdia_pkg::signed_sat(sum[51], 64'(rsp.quo));
            t_ok  <= 1'b1;
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          done      <= 1'b1;
          out_value <= t_ok ? t_val : '0;
          out_valid <= t_ok;
          state     <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/sdia_checker.sv -----
// ---------------------------------------------------------------------------
// sdia_checker
// Watches the item, result and register channels of the sample ring averager.
// It keeps its own copy of the ring and the registers, works out the result
// that each accepted word should give, and counts every mismatch.
// ---------------------------------------------------------------------------
module sdia_checker
  import sdia_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               kind,
  input  logic [9:0]         slot_index,
  input  logic [9:0]         window_start,
  input  logic signed [31:0] sample_value,
  input  logic               sample_present,
  input  logic               first_sample,
  input  logic [31:0]        time_step,
  input  logic               done,
  input  logic signed [47:0] out_value,
  input  logic               out_valid,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam longint TOP48 = 64'sd140737488355327;
  localparam longint BOT48 = -64'sd140737488355328;

  typedef struct {
    logic signed [47:0] value;
    logic               valid;
  } ring_result_t;

  longint      raw_mem   [RING_DEPTH];
  longint      xform_mem [RING_DEPTH];
  bit          raw_ok    [RING_DEPTH];
  bit          xform_ok  [RING_DEPTH];
  logic [1:0]  mode_q;
  longint      scale_q, offset_q, span_q;
  int unsigned period_q;

  ring_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic longint clip48(longint x);
    if (x > TOP48) return TOP48;
    if (x < BOT48) return BOT48;
    return x;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint signed_clip(bit neg, longint unsigned m);
    if (neg) return (m > 64'h8000_0000_0000) ? BOT48 : -longint'(m);
    return (m > 64'h7FFF_FFFF_FFFF) ? TOP48 : longint'(m);
  endfunction

  // cur - prev folded into [-span/2, span/2) on a cyclic range
  function longint wrapped_delta(longint cur, longint prv);
    longint d;
    d = cur - prv;
    if (span_q > 0) begin
      d = d % span_q;
      if (d < 0) d += span_q;
      if (2 * d >= span_q) d -= span_q;
    end
    return d;
  endfunction

  // n * dt / 2^17, split so the product never overflows
  function automatic longint half_area(longint n, longint unsigned dt);
    longint unsigned m, a, b, q;
    m = magnitude(n);
    a = m * (dt >> 16);
    b = m * (dt & 64'hFFFF);
    q = (a >> 1) + ((((a & 64'd1) << 16) + b) >> 17);
    return signed_clip(n < 0, q);
  endfunction

  function automatic longint scaled(longint t, longint s);
    longint unsigned mt, ms, q;
    mt = magnitude(t);
    ms = magnitude(s);
    q  = mt * (ms >> 16) + ((mt * (ms & 64'hFFFF)) >> 16);
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    return signed_clip((t < 0) != (s < 0), q);
  endfunction

  function ring_result_t insert_sample(int slot, longint cur, bit present, bit first,
                                       longint unsigned dt);
    ring_result_t r;
    int     prv;
    longint t, p, pt;
    bit     v, pv, ptv;
    prv = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
    t = 0;
    v = 0;
    if (!present) begin
      raw_mem[slot] = 0;
      raw_ok[slot]  = 0;
    end else begin
      p   = raw_mem[prv];
      pv  = raw_ok[prv];
      ptv = xform_ok[prv];
      pt  = xform_mem[prv];
      raw_mem[slot] = cur;
      raw_ok[slot]  = 1;
      if (first) begin
        if (mode_q == MODE_RAW || mode_q == MODE_CUMUL) begin
          t = cur;
          v = 1;
        end else if (mode_q == MODE_INTEG) begin
          v = 1;
        end
      end else begin
        case (mode_q)
          MODE_RAW: begin
            t = cur;
            v = 1;
          end
          MODE_DERIV: begin
            if (dt != 0 && pv) begin
              t = clip48((wrapped_delta(cur, p) * 65536) / longint'(dt));
              v = 1;
            end
          end
          MODE_INTEG: begin
            v = 1;
            if (pv) begin
              t = half_area((span_q > 0 && ptv) ? 2 * p + wrapped_delta(cur, p) : p + cur, dt);
              if (ptv) t = clip48(pt + t);
            end
          end
          default: begin
            v = 1;
            if (!pv) t = cur;
            else if (!ptv) t = p + cur;
            else if (span_q > 0) t = clip48(pt + p + wrapped_delta(cur, p));
            else t = clip48(pt + cur);
          end
        endcase
      end
    end
    xform_mem[slot] = t;
    xform_ok[slot]  = v;
    r.value = v ? t[47:0] : '0;
    r.valid = v;
    return r;
  endfunction

  function ring_result_t read_average(int pos, int stop);
    ring_result_t r;
    int unsigned  n;
    longint       sum, cnt;
    n = period_q;
    if (n == 0) n = 1;
    if (n > AVERAGE_MAX) n = AVERAGE_MAX;
    sum = 0;
    cnt = 0;
    r.value = '0;
    r.valid = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (xform_ok[pos]) begin
        sum += clip48(scaled(xform_mem[pos], scale_q) + offset_q);
        cnt++;
      end
      if (i == 0 && cnt == 0) return r;
      if (i != n - 1) begin
        if (pos == stop) return r;
        pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
      end
    end
    if (cnt > 0) begin
      sum = clip48(sum / cnt);
      r.value = sum[47:0];
      r.valid = 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t e;
    if (rst) begin
      foreach (raw_mem[i]) begin
        raw_mem[i]   = 0;
        xform_mem[i] = 0;
        raw_ok[i]    = 0;
        xform_ok[i]  = 0;
      end
      mode_q   = MODE_RAW;
      scale_q  = 65536;
      offset_q = 0;
      period_q = 1;
      span_q   = 0;
      expected_results.delete();
      errors   <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d valid=%0b", $time, out_value, out_valid);
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_value !== e.value || out_valid !== e.valid) begin
            $display("%0t: result mismatch expected value=%0d valid=%0b, got value=%0d valid=%0b",
                     $time, e.value, e.valid, out_value, out_valid);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   mode_q   = cfg_data[1:0];
          CFG_SCALE:  scale_q  = longint'(signed'(cfg_data));
          CFG_OFFSET: offset_q = longint'(signed'(cfg_data));
          CFG_PERIOD: period_q = cfg_data[4:0];
          CFG_SPAN:   span_q   = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (kind == KIND_INSERT)
          e = insert_sample(slot_index, longint'(sample_value), sample_present, first_sample,
                            time_step);
        else
          e = read_average(slot_index, window_start);
        expected_results.push_back(e);
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sample ring averager. A short directed pass
// runs every transform mode through its first-sample, zero-step and
// invalid-neighbour cases, then random phases stream runs of inserts and windowed
// reads, with some noise words, under varied register settings. The checker
// beside the block does all prediction and comparison.
// ---------------------------------------------------------------------------
module tb;
  import sdia_pkg::*;

  localparam int LIMIT = 3_000_000;   // cycles, well above the slowest run

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               kind = KIND_INSERT;
  logic [9:0]         slot_index = '0;
  logic [9:0]         window_start = '0;
  logic signed [31:0] sample_value = '0;
  logic               sample_present = 0;
  logic               first_sample = 0;
  logic [31:0]        time_step = '0;
  logic               cfg_valid = 0;
  logic [2:0]         cfg_index = CFG_MODE;
  logic [31:0]        cfg_data = '0;
  wire                busy, done, out_valid, cfg_ready;
  wire signed [47:0]  out_value;
  int                 errors, pending;
  int                 cycles = 0;
  bit                 idling = 1;     // random gaps between words

  // stream position for the random part
  int                 head;
  int                 win;

  always #5 clk = ~clk;

  sample_derivative_integral_averager dut (.*);

  sdia_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // optional burst of idle cycles, start dropped throughout
  task automatic maybe_gap();
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // present one word and hold it until busy is seen low before an edge
  task automatic send_word(logic k, int slot, int ws, logic signed [31:0] val, logic pres,
                           logic first, logic [31:0] dt);
    maybe_gap();
    start          <= 1;
    kind           <= k;
    slot_index     <= slot[9:0];
    window_start   <= ws[9:0];
    sample_value   <= val;
    sample_present <= pres;
    first_sample   <= first;
    time_step      <= dt;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // wait for the block to drain; busy covers the clear after reset too
  task automatic drain();
    start <= 0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      5:       return $signed($urandom_range(0, 400 << 16)) - (200 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(1, 4 << 16);
      default: return $urandom;
    endcase
  endfunction

  // one random word: mostly a continuing stream, some reads, some noise
  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_word(KIND_INSERT, head, win, pick_sample(), $urandom_range(0, 9) != 0,
                head == win, pick_step());
      head = (head + 1) % RING_DEPTH;
    end else if (r < 88) begin
      send_word(KIND_READ, (head + RING_DEPTH - 1 - $urandom_range(0, 3)) % RING_DEPTH,
                win, '0, 0, 0, '0);
    end else begin
      // noise: anywhere, any flags
      send_word($urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
    end
  endtask

  initial begin
    logic [31:0] span_pick;
    repeat (12) @(posedge clk);
    rst <= 0;
    drain();

    // directed: each mode over first sample, normal, zero step, absent, after absent
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_MODE, m);
      send_word(KIND_INSERT, 1023, 0, 32'sh7FFF_FFFF, 1, 1, 32'hFFFF_FFFF);
      send_word(KIND_INSERT, 0, 1023, 32'sh8000_0000, 1, 0, 32'h0001_0000);
      send_word(KIND_INSERT, 1, 1023, 32'sh0003_0000, 1, 0, 32'd0);
      send_word(KIND_INSERT, 2, 1023, 32'sh0001_0000, 0, 0, 32'h0002_0000);
      send_word(KIND_INSERT, 3, 1023, -32'sh0002_8000, 1, 0, 32'h0000_8000);
      send_word(KIND_READ, 3, 1023, '0, 0, 0, '0);
      drain();
    end

    // random phases, each under its own register setting; the last two run without gaps
    for (int ph = 0; ph < 10; ph++) begin
      idling = (ph < 8);
      write_reg(CFG_MODE, ph % 4);
      case (ph % 5)
        0:       span_pick = 32'd0;
        1:       span_pick = 32'h7FFF_FFFF;
        2:       span_pick = 360 << 16;
        3:       span_pick = $urandom_range(1, 1 << 20);
        default: span_pick = $urandom;
      endcase
      write_reg(CFG_SPAN, span_pick);
      case (ph % 4)
        0:       write_reg(CFG_SCALE, 32'h8000_0000);
        1:       write_reg(CFG_SCALE, 32'h7FFF_FFFF);
        2:       write_reg(CFG_SCALE, 32'h0001_0000);
        default: write_reg(CFG_SCALE, $urandom);
      endcase
      case (ph % 3)
        0:       write_reg(CFG_OFFSET, 32'h8000_0000);
        1:       write_reg(CFG_OFFSET, 32'h7FFF_FFFF);
        default: write_reg(CFG_OFFSET, $urandom_range(0, 1 << 18));
      endcase
      // long averages are slow, so most phases keep the period short
      write_reg(CFG_PERIOD, (ph == 3 || ph == 6) ? AVERAGE_MAX :
                            (ph % 2 ? 1 : $urandom_range(1, 4)));
      head = $urandom_range(0, 1023);
      win  = head;
      repeat (63) random_word();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sample_derivative_integral_averager.f -----
hw/rtl/sdia_pkg.sv
hw/rtl/sdia_iter_unit.sv
hw/rtl/sample_derivative_integral_averager.sv
tb/sv/sdia_checker.sv
tb/sv/tb.sv
